@@ sv/dwd_pkg.sv @@
// Shared constants, types and calendar helper functions for the date/weekday block.
`timescale 1ns / 1ps
`default_nettype none

package dwd_pkg;

  // Field widths
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 7;
  localparam int DAY_W       = 7;
  localparam int MCODE_W     = 4;
  localparam int CFG_MONTH_W = 4;
  localparam int CFG_DAY_W   = 5;
  localparam int STATUS_W    = 2;
  localparam int WDAY_W      = 3;
  localparam int DAYS_W      = 22;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  // Internal widths of the day-number datapath
  localparam int DN_W    = 23;  // day number on the shifted epoch
  localparam int YY_W    = 15;  // shifted year, up to 16383 + 400
  localparam int DOY_W   = 9;   // month offset plus day
  localparam int PROD_W  = 25;  // (year / 4) * reciprocal of 25
  localparam int Q_W     = 8;   // year / 100
  localparam int Y4_W    = 12;  // input year / 4
  localparam int MLEN_W  = 5;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Constants
  localparam logic [YEAR_W-1:0]    FIRST_YEAR    = 14'd1900;
  localparam logic [YY_W-1:0]      YEAR_SHIFT    = 15'd400;
  localparam logic [DN_W-1:0]      DAYS_PER_YEAR = 23'd365;
  localparam logic [PROD_W-1:0]    DIV25_MUL     = 25'd5243;
  localparam int                   DIV25_SHIFT   = 17;
  localparam logic [Y4_W-1:0]      DIV25_DIVISOR = 12'd25;
  // Day number of 1899-12-31, so that 1900-01-01 lands on weekday 1
  localparam logic [DN_W-1:0]      WDAY_BASE     = 23'd839998;
  localparam logic [DAYS_W-1:0]    DAYS_MAX      = 22'h3FFFFF;
  localparam logic [MONTH_W-1:0]   MONTH_MAX     = 7'd12;
  localparam logic [CFG_MONTH_W-1:0] CFG_MONTH_MAX = 4'd12;
  localparam logic [MCODE_W-1:0]   MONTH_FEB     = 4'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FUTURE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY   = 2'd2;

  // Configuration reset values
  localparam logic [YEAR_W-1:0]      TODAY_YEAR_RST  = 14'd2021;
  localparam logic [CFG_MONTH_W-1:0] TODAY_MONTH_RST = 4'd3;
  localparam logic [CFG_DAY_W-1:0]   TODAY_DAY_RST   = 5'd9;

  // One classified date on its way from front to back
  typedef struct packed {
    logic            invalid;
    logic [DN_W-1:0] dn;
  } dwd_item_t;

  // Days before the first of a month in a year that starts in March.
  function automatic logic [DOY_W-1:0] month_offset(input logic [MCODE_W-1:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month; zero for a code that is no month.
  function automatic logic [MLEN_W-1:0] month_days(input logic [MCODE_W-1:0] m,
                                                   input logic leap);
    logic [MLEN_W-1:0] r;
    unique case (m)
      4'd2:                            r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:         r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                    r = 5'd31;
      default:                         r = 5'd0;
    endcase
    return r;
  endfunction

  // Remainder by seven: octal digits sum to the same residue since 8 = 1 mod 7.
  function automatic logic [WDAY_W-1:0] mod7(input logic [DN_W-1:0] x);
    logic [DN_W:0] xe;
    logic [5:0]    s1;
    logic [3:0]    s2;
    logic [2:0]    s3;
    xe = {1'b0, x};
    s1 = '0;
    for (int i = 0; i < (DN_W + 1) / 3; i++) begin
      s1 = s1 + 6'(xe[3*i +: 3]);
    end
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = {2'b00, s2[3]} + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

@@ sv/dwd_daynum.sv @@
// Three-stage pipeline that turns a calendar date into a linear day number.
`timescale 1ns / 1ps
`default_nettype none

module dwd_daynum (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [dwd_pkg::YEAR_W-1:0]  year,
  input  wire logic [dwd_pkg::MCODE_W-1:0] month,
  input  wire logic [dwd_pkg::DAY_W-1:0]   day,
  output logic      [dwd_pkg::DN_W-1:0]    dn
);

  logic [dwd_pkg::YY_W-1:0]   yy_a;
  logic [dwd_pkg::DOY_W-1:0]  doy_a;
  logic [dwd_pkg::DN_W-1:0]   base_b;
  logic [dwd_pkg::PROD_W-1:0] pq_b;
  logic [dwd_pkg::YY_W-3:0]   yy4_b;
  logic [dwd_pkg::DOY_W-1:0]  doy_b;
  logic [dwd_pkg::Q_W-1:0]    q100;
  logic [dwd_pkg::Q_W-3:0]    q400;
  logic                       early;

  // January and February count as months of the previous year.
  assign early = (month <= dwd_pkg::MONTH_FEB);

  // Stage A: shifted year and day within the March-based year.
  always_ff @(posedge clk) begin
    if (en) begin
      yy_a  <= dwd_pkg::YY_W'(year) + dwd_pkg::YEAR_SHIFT - dwd_pkg::YY_W'(early);
      doy_a <= dwd_pkg::month_offset(month) + dwd_pkg::DOY_W'(day);
    end
  end

  // Stage B: days of whole years and the product for the division by 100.
  always_ff @(posedge clk) begin
    if (en) begin
      base_b <= dwd_pkg::DN_W'(yy_a) * dwd_pkg::DAYS_PER_YEAR;
      pq_b   <= dwd_pkg::PROD_W'(yy_a[dwd_pkg::YY_W-1:2]) * dwd_pkg::DIV25_MUL;
      yy4_b  <= yy_a[dwd_pkg::YY_W-1:2];
      doy_b  <= doy_a;
    end
  end

  // Stage C: add the leap-day corrections.
  assign q100 = pq_b[dwd_pkg::PROD_W-1:dwd_pkg::DIV25_SHIFT];
  assign q400 = q100[dwd_pkg::Q_W-1:2];

  always_ff @(posedge clk) begin
    if (en) begin
      dn <= base_b + dwd_pkg::DN_W'(yy4_b) - dwd_pkg::DN_W'(q100)
            + dwd_pkg::DN_W'(q400) + dwd_pkg::DN_W'(doy_b);
    end
  end

endmodule

`default_nettype wire

@@ sv/dwd_front.sv @@
// Front end: accepts dates, checks them and computes their day numbers.
`timescale 1ns / 1ps
`default_nettype none

module dwd_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata: birth_year [13:0], birth_month [20:14], birth_day [27:21], zero fill
  input  wire logic [dwd_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                                 item_valid,
  input  wire logic                            item_ready,
  output dwd_pkg::dwd_item_t                   item
);

  logic [dwd_pkg::YEAR_W-1:0]  in_year;
  logic [dwd_pkg::MONTH_W-1:0] in_month;
  logic [dwd_pkg::DAY_W-1:0]   in_day;
  logic                        en;

  logic                        va, vb, vc;
  logic [dwd_pkg::Y4_W-1:0]    y4_a;
  logic [1:0]                  ylo_a;
  logic [dwd_pkg::PROD_W-1:0]  pl_a;
  logic                        ybad_a;
  logic [dwd_pkg::MONTH_W-1:0] month_a;
  logic [dwd_pkg::DAY_W-1:0]   day_a;
  logic                        invalid_b, invalid_c;

  logic [dwd_pkg::Q_W-1:0]     q25;
  logic [dwd_pkg::Y4_W-1:0]    rem25;
  logic                        div100, leap, mbad, dbad;
  logic [dwd_pkg::MLEN_W-1:0]  mlen;
  logic [dwd_pkg::DN_W-1:0]    dn;

  assign in_year  = s_tdata[13:0];
  assign in_month = s_tdata[20:14];
  assign in_day   = s_tdata[27:21];

  // The whole front advances together; it holds only while its last item waits.
  assign en       = !vc || item_ready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
      vc <= vb;
    end
  end

  // Stage A: register the date and start the division of the year by 100.
  always_ff @(posedge clk) begin
    if (en) begin
      y4_a    <= in_year[dwd_pkg::YEAR_W-1:2];
      ylo_a   <= in_year[1:0];
      pl_a    <= dwd_pkg::PROD_W'(in_year[dwd_pkg::YEAR_W-1:2]) * dwd_pkg::DIV25_MUL;
      ybad_a  <= (in_year < dwd_pkg::FIRST_YEAR);
      month_a <= in_month;
      day_a   <= in_day;
    end
  end

  // Stage B: leap rule and range checks of month and day.
  assign q25    = pl_a[dwd_pkg::PROD_W-1:dwd_pkg::DIV25_SHIFT];
  assign rem25  = y4_a - dwd_pkg::Y4_W'(q25) * dwd_pkg::DIV25_DIVISOR;
  assign div100 = (ylo_a == 2'd0) && (rem25 == '0);
  assign leap   = (ylo_a == 2'd0) && (!div100 || (q25[1:0] == 2'd0));
  assign mbad   = (month_a == '0) || (month_a > dwd_pkg::MONTH_MAX);
  assign mlen   = dwd_pkg::month_days(month_a[dwd_pkg::MCODE_W-1:0], leap);
  assign dbad   = (day_a == '0) || (day_a > dwd_pkg::DAY_W'(mlen));

  always_ff @(posedge clk) begin
    if (en) begin
      invalid_b <= ybad_a || mbad || dbad;
      invalid_c <= invalid_b;
    end
  end

  // Day number runs alongside the checks with the same depth.
  dwd_daynum u_daynum (
    .clk   (clk),
    .en    (en),
    .year  (in_year),
    .month (in_month[dwd_pkg::MCODE_W-1:0]),
    .day   (in_day),
    .dn    (dn)
  );

  assign item_valid   = vc;
  assign item.invalid = invalid_c;
  assign item.dn      = dn;

endmodule

`default_nettype wire

@@ sv/dwd_queue.sv @@
// Small register-based queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dwd_queue #(
  parameter int DEPTH = dwd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dwd_pkg::dwd_item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dwd_pkg::dwd_item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dwd_pkg::dwd_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dwd_back.sv @@
// Back end: compares against the reference day number and forms the result.
`timescale 1ns / 1ps
`default_nettype none

module dwd_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire dwd_pkg::dwd_item_t               item,
  input  wire logic [dwd_pkg::DN_W-1:0]        ref_dn,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata: status [1:0], weekday [4:2], days_past [26:5], zero fill
  output logic      [dwd_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic                          future;
  logic [dwd_pkg::DN_W-1:0]      diff;
  logic [dwd_pkg::STATUS_W-1:0]  status_next;
  logic [dwd_pkg::WDAY_W-1:0]    wday_next;
  logic [dwd_pkg::DAYS_W-1:0]    days_next;
  logic [dwd_pkg::STATUS_W-1:0]  status;
  logic [dwd_pkg::WDAY_W-1:0]    wday;
  logic [dwd_pkg::DAYS_W-1:0]    days;
  logic                          load;

  // Result of the item at the head of the queue.
  assign future = (item.dn > ref_dn);
  assign diff   = ref_dn - item.dn;

  always_comb begin
    status_next = dwd_pkg::STATUS_OK;
    wday_next   = '0;
    days_next   = '0;
    if (item.invalid) begin
      status_next = dwd_pkg::STATUS_INVALID;
    end else if (future) begin
      status_next = dwd_pkg::STATUS_FUTURE;
    end else begin
      wday_next = dwd_pkg::mod7(item.dn - dwd_pkg::WDAY_BASE);
      days_next = (diff > dwd_pkg::DN_W'(dwd_pkg::DAYS_MAX)) ? dwd_pkg::DAYS_MAX
                                                            : diff[dwd_pkg::DAYS_W-1:0];
    end
  end

  // Output register; refilled in the same cycle its transfer completes.
  assign item_ready = !m_tvalid || m_tready;
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_ready) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      wday   <= wday_next;
      days   <= days_next;
    end
  end

  assign m_tdata = {5'd0, days, wday, status};

endmodule

`default_nettype wire

@@ sv/date_weekday_and_day_difference.sv @@
// A date accepted at the input fills the first of three front stages, then moves through the
// other two, the queue and the output register.
// Throughput: one date per cycle; the output register and a small queue decouple
// the input from stalls on the output side, so input stalls only when both are full.
// Reference registers reset to 2021-03-09; a new reference date is in effect for
// dates accepted from the cycle after its write. Reset is synchronous, active high.
`timescale 1ns / 1ps
`default_nettype none

module date_weekday_and_day_difference #(
  parameter int QUEUE_DEPTH = dwd_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata: birth_year [13:0], birth_month [20:14], birth_day [27:21], zero fill
  input  wire logic [dwd_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata: status [1:0], weekday [4:2], days_past [26:5], zero fill
  output logic      [dwd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [dwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dwd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [dwd_pkg::YEAR_W-1:0]      today_year;
  logic [dwd_pkg::CFG_MONTH_W-1:0] today_month;
  logic [dwd_pkg::CFG_DAY_W-1:0]   today_day;
  logic [dwd_pkg::MCODE_W-1:0]     ref_month;
  logic [dwd_pkg::DN_W-1:0]        ref_dn;

  logic               f_valid, f_ready, b_valid, b_ready;
  dwd_pkg::dwd_item_t f_item, b_item;

  // Reference date registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      today_year  <= dwd_pkg::TODAY_YEAR_RST;
      today_month <= dwd_pkg::TODAY_MONTH_RST;
      today_day   <= dwd_pkg::TODAY_DAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dwd_pkg::CFG_TODAY_YEAR:  today_year  <= cfg_data;
        dwd_pkg::CFG_TODAY_MONTH: today_month <= cfg_data[dwd_pkg::CFG_MONTH_W-1:0];
        dwd_pkg::CFG_TODAY_DAY:   today_day   <= cfg_data[dwd_pkg::CFG_DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range reference months clamp to January or December.
  always_comb begin
    if (today_month == '0) begin
      ref_month = dwd_pkg::MCODE_W'(1);
    end else if (today_month > dwd_pkg::CFG_MONTH_MAX) begin
      ref_month = dwd_pkg::CFG_MONTH_MAX;
    end else begin
      ref_month = today_month;
    end
  end

  // Reference day number, recomputed continuously.
  dwd_daynum u_ref_daynum (
    .clk   (clk),
    .en    (1'b1),
    .year  (today_year),
    .month (ref_month),
    .day   (dwd_pkg::DAY_W'(today_day)),
    .dn    (ref_dn)
  );

  dwd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  dwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  dwd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .ref_dn     (ref_dn),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the date checker: streams dates, predicts status, weekday and day count.
`timescale 1ns / 1ps

module testbench;
  import dwd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WDAY_W-1:0]   wday;
    logic [DAYS_W-1:0]   days;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the reference date registers.
  logic [YEAR_W-1:0]      ref_year = TODAY_YEAR_RST;
  logic [CFG_MONTH_W-1:0] ref_month = TODAY_MONTH_RST;
  logic [CFG_DAY_W-1:0]   ref_day = TODAY_DAY_RST;

  date_t    date_q[$];
  outcome_t outcome_q[$];
  date_t    offered;
  outcome_t want;

  int send_gap = 0, send_run = 0;
  int recv_gap = 0, recv_run = 0, hold_left = 0, longest_hold = 0;
  int results_seen = 0, mismatches = 0, quiet_cycles = 0, settings_used = 0;
  int past_count = 0, invalid_count = 0, future_count = 0, saturated_count = 0;

  date_weekday_and_day_difference uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Calendar arithmetic for the prediction.
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      2: return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Serial day number with the year starting in March, offset by 400 years.
  function automatic int unsigned day_count(input int unsigned y, input int unsigned m,
                                            input int unsigned d);
    int unsigned yy, mp;
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    mp = (m + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d;
  endfunction

  function automatic outcome_t predict_outcome(input date_t dt);
    outcome_t    o;
    int unsigned y, m, d, rm, dn, rn;
    o = '0;
    y = dt.year;
    m = dt.month;
    d = dt.day;
    if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
      o.status = STATUS_INVALID;
    end else begin
      // An out-of-range reference month is clamped into 1..12.
      rm = (ref_month < 1) ? 1 : (ref_month > 12) ? 12 : ref_month;
      dn = day_count(y, m, d);
      rn = day_count(ref_year, rm, ref_day);
      if (dn > rn) begin
        o.status = STATUS_FUTURE;
      end else begin
        o.status = STATUS_OK;
        o.wday = WDAY_W'((dn - day_count(FIRST_YEAR, 1, 1) + 1) % 7);
        o.days = (rn - dn > DAYS_MAX) ? DAYS_MAX : DAYS_W'(rn - dn);
      end
    end
    return o;
  endfunction

  // Idle length for either side: mostly short, a few long, with runs of none.
  function automatic int pick_gap(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_t make_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
    date_t dt;
    dt.year = YEAR_W'(y);
    dt.month = MONTH_W'(m);
    dt.day = DAY_W'(d);
    return dt;
  endfunction

  // Mostly well-formed dates up to the reference year, some later ones, plus month ends and raw noise.
  function automatic date_t random_date();
    int r;
    int unsigned y, m, d, len, top;
    r = $urandom_range(0, 99);
    top = (ref_year > FIRST_YEAR) ? ref_year : FIRST_YEAR;
    if (r >= 80) begin
      return make_date($urandom_range(0, 16383), $urandom_range(0, 127),
                       $urandom_range(0, 127));
    end
    if (r < 50) y = $urandom_range(FIRST_YEAR, top);
    else if (r < 58) y = top;
    else y = $urandom_range(FIRST_YEAR, 16383);
    m = $urandom_range(1, 12);
    len = days_in_month(y, m);
    if (r < 70) begin
      d = $urandom_range(1, len);
    end else begin
      case ($urandom_range(0, 2))
        0: d = len;
        1: d = len + 1;
        default: begin
          m = 2;
          d = 29;
        end
      endcase
    end
    return make_date(y, m, d);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned exp_val,
                                 input longint unsigned got_val);
    mismatches++;
    $display("MISMATCH %s on result %0d: expected %0d, got %0d",
             what, results_seen, exp_val, got_val);
  endtask

  // Wait until no date is pending or in flight, then let the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (date_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    case (idx)
      CFG_TODAY_YEAR: ref_year = YEAR_W'(value);
      CFG_TODAY_MONTH: ref_month = CFG_MONTH_W'(value);
      default: ref_day = CFG_DAY_W'(value);
    endcase
  endtask

  // New reference date while idle, then a batch of random dates against it.
  task automatic run_setting(input int unsigned y, input int unsigned m, input int unsigned d);
    wait_drained();
    set_register(CFG_TODAY_YEAR, y);
    set_register(CFG_TODAY_MONTH, m);
    set_register(CFG_TODAY_DAY, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    for (int i = 0; i < PHASE_ITEMS; i++) date_q.push_back(random_date());
  endtask

  // Stimulus: reset, directed dates at the reset reference, then setting sweeps.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    date_q.push_back(make_date(1900, 1, 1));     // first valid day, a Monday
    date_q.push_back(make_date(1899, 12, 31));   // year before the first
    date_q.push_back(make_date(0, 0, 0));
    date_q.push_back(make_date(16383, 127, 127));
    date_q.push_back(make_date(2021, 3, 9));     // the reference day itself
    date_q.push_back(make_date(2021, 3, 10));    // one day after the reference
    date_q.push_back(make_date(2000, 2, 29));    // leap by the 400 rule
    date_q.push_back(make_date(1900, 2, 29));    // century year, not leap
    date_q.push_back(make_date(2020, 2, 29));
    date_q.push_back(make_date(2021, 2, 29));
    date_q.push_back(make_date(2004, 2, 30));
    date_q.push_back(make_date(2020, 4, 31));
    date_q.push_back(make_date(2020, 4, 30));
    date_q.push_back(make_date(2020, 12, 31));
    date_q.push_back(make_date(2020, 13, 1));
    date_q.push_back(make_date(2020, 0, 15));
    date_q.push_back(make_date(2020, 1, 0));
    date_q.push_back(make_date(2020, 1, 32));
    date_q.push_back(make_date(12000, 6, 15));   // year past four digits
    date_q.push_back(make_date(1999, 12, 31));
    for (int i = 0; i < PHASE_ITEMS; i++) date_q.push_back(random_date());

    run_setting(1900, 1, 1);
    run_setting(9999, 12, 31);
    run_setting(16383, 15, 31);   // month clamps to 12, long counts saturate
    run_setting(1899, 6, 15);     // reference before the first year
    run_setting(2000, 0, 0);      // month 0 and day 0
    run_setting(2023, 2, 31);     // day past the month end rolls over
    run_setting(1950, 13, 0);
    run_setting($urandom_range(1900, 9999), $urandom_range(1, 12), $urandom_range(1, 28));

    wait_drained();
    $display("Checked %0d dates under %0d reference settings: %0d counted, %0d invalid, %0d ahead",
             results_seen, settings_used, past_count, invalid_count, future_count);
    $display("Saturated day counts: %0d; longest output hold-off: %0d cycles",
             saturated_count, longest_hold);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Input driver: offer queued dates with random gaps, predict on each transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) outcome_q.push_back(predict_outcome(offered));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (date_q.size() != 0) begin
          offered = date_q.pop_front();
          s_tdata <= IN_TDATA_W'({offered.day, offered.month, offered.year});
          s_tvalid <= 1'b1;
          send_gap = pick_gap(send_run);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing expected", 0, m_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata[STATUS_W-1:0] !== want.status)
            report_mismatch("status", want.status, m_tdata[STATUS_W-1:0]);
          if (m_tdata[STATUS_W +: WDAY_W] !== want.wday)
            report_mismatch("weekday", want.wday, m_tdata[STATUS_W +: WDAY_W]);
          if (m_tdata[STATUS_W+WDAY_W +: DAYS_W] !== want.days)
            report_mismatch("days_past", want.days, m_tdata[STATUS_W+WDAY_W +: DAYS_W]);
          case (want.status)
            STATUS_OK: past_count++;
            STATUS_INVALID: invalid_count++;
            default: future_count++;
          endcase
          if (want.status == STATUS_OK && want.days == DAYS_MAX) saturated_count++;
        end
        // Long hold-off so the block fills up and stalls its input.
        if (results_seen == 400 || results_seen == 1100) begin
          hold_left = $urandom_range(120, 200);
          if (hold_left > longest_hold) longest_hold = hold_left;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap(recv_run);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout after %0d quiet cycles with %0d results pending",
               QUIET_LIMIT, outcome_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
